### design/gb5_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the 5x5 binomial blur block.
// No dependencies; every other file of the block imports this package.
package gb5_pkg;

    // Line storage geometry.
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int MIN_SIZE   = 5;

    // Pixel and channel widths.
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LINES      = 4;
    localparam int LB_WORD_W  = LINES * PIX_W;
    localparam int TAPS       = 5;

    // Sum widths: a vertical sum is at most 10 * 255, the full 5x5 sum 100 * 255.
    localparam int VSUM_W     = 12;
    localparam int HSUM_W     = 15;

    // Division by 100 as multiply by 5243 and shift right by 19; exact for sums below 25600.
    localparam int DIV_MUL_W  = 13;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5243;
    localparam int DIV_SHIFT  = 19;
    localparam int PROD_W     = HSUM_W + DIV_MUL_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [COL_W-1:0] RESET_WIDTH_M1  = 10'd639;
    localparam logic [ROW_W-1:0] RESET_HEIGHT_M1 = 12'd479;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int PEND_W     = 3;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [PIX_W-1:0]     pix_word_t;
    typedef logic [LB_WORD_W-1:0] lb_word_t;
    typedef logic [VSUM_W-1:0]    vsum_t;

    // Flags that travel with a pixel down the pipeline.
    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } pix_flags_t;

    // One queued result item.
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
        logic  frame_end;
    } result_t;

endpackage

### design/gb5_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the blur block: pixel requests, result requests and
// configuration writes. Depends on gb5_pkg for field widths.

interface gb5_pix_if
    import gb5_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t blue_in;
    chan_t green_in;
    chan_t red_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    input ready);
    modport sink   (input valid, input blue_in, input green_in, input red_in,
                    output ready);
endinterface

interface gb5_res_if
    import gb5_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t blue_out;
    chan_t green_out;
    chan_t red_out;
    logic  row_end;
    logic  frame_end;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output row_end, output frame_end, input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    input row_end, input frame_end, output ready);
endinterface

interface gb5_cfg_if
    import gb5_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/gb5_line_buf.sv
`timescale 1ns / 1ps
// Four-line pixel store: one word per column holds the four rows above.
// Depends on gb5_pkg for the word layout and depth.
module gb5_line_buf
    import gb5_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output lb_word_t         rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  lb_word_t         wr_data
);

    lb_word_t mem [MAX_WIDTH];
    lb_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/gb5_lane.sv
`timescale 1ns / 1ps
// One color lane: vertical 1-2-4-2-1 sum, five-column window, horizontal sum
// and division by 100. Depends on gb5_pkg.
module gb5_lane
    import gb5_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  chan_t col_pix [TAPS],
    output chan_t quotient
);

    vsum_t              vsum;
    vsum_t              win_reg [TAPS];
    logic [HSUM_W-1:0]  hsum_next;
    logic [HSUM_W-1:0]  hsum_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Vertical weights: rows top to bottom are 1, 2, 4, 2, 1.
    assign vsum = {4'b0, col_pix[0]} + {3'b0, col_pix[1], 1'b0} + {2'b0, col_pix[2], 2'b0}
                + {3'b0, col_pix[3], 1'b0} + {4'b0, col_pix[4]};

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[TAPS - 1] <= vsum;
        end
    end

    assign hsum_next = {3'b0, win_reg[0]} + {2'b0, win_reg[1], 1'b0}
                     + {1'b0, win_reg[2], 2'b0} + {2'b0, win_reg[3], 1'b0}
                     + {3'b0, win_reg[4]};

    always_ff @(posedge clk)
    begin
        hsum_reg <= hsum_next;
        prod_reg <= PROD_W'(hsum_reg) * PROD_W'(DIV_MUL);
    end

    assign quotient = prod_reg[DIV_SHIFT +: CHAN_W];

endmodule

### design/gb5_merge.sv
`timescale 1ns / 1ps
// Merges the three lane results and the pixel flags into result requests and
// queues them for the output channel. Depends on gb5_pkg and gb5_if.
module gb5_merge
    import gb5_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  chan_t                 red,
    input  chan_t                 green,
    input  chan_t                 blue,
    input  logic                  row_end,
    input  logic                  frame_end,
    output logic [FIFO_CNT_W-1:0] count,
    gb5_res_if.source             res
);

    result_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;
    result_t               head;

    assign pop = res.valid && res.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{red: red, green: green, blue: blue,
                                      row_end: row_end, frame_end: frame_end};
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head          = fifo_mem[rd_ptr_reg];
    assign res.valid     = (count_reg != '0);
    assign res.red_out   = head.red;
    assign res.green_out = head.green;
    assign res.blue_out  = head.blue;
    assign res.row_end   = head.row_end;
    assign res.frame_end = head.frame_end;
    assign count         = count_reg;

endmodule

### design/gaussian_blur_5x5_rgb_stream.sv
`timescale 1ns / 1ps
// 5x5 binomial blur of an RGB pixel stream: top level with counters, pipeline and credits.
// Depends on gb5_pkg, gb5_if, gb5_line_buf, gb5_lane and gb5_merge.

// The block takes one pixel request per clock in raster order and returns one
// blurred pixel for every position at least two pixels from each border. That
// result passes in turn through the line store read, column window, horizontal sum
// and product registers into the queue that offers it on the result channel. Each
// channel runs in its own lane with the kernel 1,2,4,2,1 applied vertically and
// then horizontally, and the sum is divided by 100 with truncation. Results wait
// in an eight-entry queue, so pixel requests keep flowing while the output side
// stalls; the pixel channel drops ready only when the queue plus the results still
// in flight would fill it. The sustained rate is one pixel per clock, set by the
// single read and single write port of the line store, which are both used once
// per pixel. Image width and height are written through the configuration
// channel (width clamped to 5..1024, height to 5..4096), and any write to either
// register restarts the frame at its first pixel. Configuration should only be
// written while no pixel is in flight. The line store has no reset; every entry
// that feeds a result is written earlier in the same frame.

module gaussian_blur_5x5_rgb_stream
    import gb5_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gb5_pix_if.sink   video,
    gb5_res_if.source blurred,
    gb5_cfg_if.sink   cfg
);

    // Geometry, stored as size minus one after clamping.
    logic [COL_W-1:0] wm1_reg;
    logic [COL_W-1:0] wm1_next;
    logic [ROW_W-1:0] hm1_reg;
    logic [ROW_W-1:0] hm1_next;

    // Raster position of the next pixel.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             cfg_fire;
    logic             cfg_hit;
    logic             in_fire;
    logic             last_col;
    logic             last_row;
    pix_flags_t       flags;

    logic [IMG_W_W-1:0] raw_w;
    logic [IMG_H_W-1:0] raw_h;

    // Stage 1: line store read in flight.
    logic             s1_valid_reg;
    pix_flags_t       s1_flags_reg;
    pix_word_t        s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    lb_word_t         lb_rd_data;
    lb_word_t         lb_wr_data;

    // Stages 2 to 4: only results that will be produced are tracked.
    logic             s2_push_reg;
    logic             s3_push_reg;
    logic             s4_push_reg;
    logic [1:0]       s2_tag_reg;
    logic [1:0]       s3_tag_reg;
    logic [1:0]       s4_tag_reg;

    logic [PEND_W-1:0]     pending;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  credit_ok;

    chan_t blue_col  [TAPS];
    chan_t green_col [TAPS];
    chan_t red_col   [TAPS];
    chan_t blue_q;
    chan_t green_q;
    chan_t red_q;

    // ------------------------------------------------------------------
    // Configuration. The channel is always ready; a write to a known index
    // updates the geometry and restarts the frame.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign raw_w     = cfg.data[IMG_W_W-1:0];
    assign raw_h     = cfg.data[IMG_H_W-1:0];

    always_comb
    begin
        wm1_next = wm1_reg;
        hm1_next = hm1_reg;
        cfg_hit  = 1'b0;
        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:
                begin
                    cfg_hit = 1'b1;
                    if (raw_w < IMG_W_W'(MIN_SIZE))
                        wm1_next = COL_W'(MIN_SIZE - 1);
                    else if (raw_w > IMG_W_W'(MAX_WIDTH))
                        wm1_next = COL_W'(MAX_WIDTH - 1);
                    else
                        wm1_next = COL_W'(raw_w - 1'b1);
                end
                CFG_IMAGE_HEIGHT:
                begin
                    cfg_hit = 1'b1;
                    if (raw_h < IMG_H_W'(MIN_SIZE))
                        hm1_next = ROW_W'(MIN_SIZE - 1);
                    else if (raw_h > IMG_H_W'(MAX_HEIGHT))
                        hm1_next = ROW_W'(MAX_HEIGHT - 1);
                    else
                        hm1_next = ROW_W'(raw_h - 1'b1);
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Raster counters and per-pixel flags, taken at the accepting edge.
    // ------------------------------------------------------------------
    assign in_fire  = video.valid && video.ready;
    assign last_col = (col_reg == wm1_reg);
    assign last_row = (row_reg == hm1_reg);

    assign flags.produce   = (row_reg >= ROW_W'(TAPS - 1)) && (col_reg >= COL_W'(TAPS - 1));
    assign flags.row_end   = last_col;
    assign flags.frame_end = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= RESET_WIDTH_M1;
            hm1_reg <= RESET_HEIGHT_M1;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            wm1_reg <= wm1_next;
            hm1_reg <= hm1_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The column is read at acceptance and rewritten in the next
    // cycle with the column shifted up by one row. A column is revisited only
    // after a full row, so the write always lands before the next read.
    // ------------------------------------------------------------------
    gb5_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr_data)
    );

    assign lb_wr_data = {s1_pix_reg, lb_rd_data[LB_WORD_W-1:PIX_W]};

    // Control state of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_push_reg  <= 1'b0;
            s3_push_reg  <= 1'b0;
            s4_push_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s2_push_reg  <= s1_valid_reg && s1_flags_reg.produce;
            s3_push_reg  <= s2_push_reg;
            s4_push_reg  <= s3_push_reg;
        end
    end

    // Payload registers of the pipeline. The tag carries row end and frame end.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flags_reg <= flags;
            s1_pix_reg   <= {video.red_in, video.green_in, video.blue_in};
            s1_addr_reg  <= col_reg;
        end
        s2_tag_reg <= {s1_flags_reg.row_end, s1_flags_reg.frame_end};
        s3_tag_reg <= s2_tag_reg;
        s4_tag_reg <= s3_tag_reg;
    end

    // ------------------------------------------------------------------
    // Color lanes. Column taps run from the oldest stored row down to the
    // pixel just accepted.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            blue_col[i]  = lb_rd_data[i * PIX_W +: CHAN_W];
            green_col[i] = lb_rd_data[i * PIX_W + CHAN_W +: CHAN_W];
            red_col[i]   = lb_rd_data[i * PIX_W + 2 * CHAN_W +: CHAN_W];
        end
        blue_col[LINES]  = s1_pix_reg[CHAN_W-1:0];
        green_col[LINES] = s1_pix_reg[2*CHAN_W-1:CHAN_W];
        red_col[LINES]   = s1_pix_reg[PIX_W-1:2*CHAN_W];
    end

    gb5_lane u_lane_blue (
        .clk      (clk),
        .shift    (s1_valid_reg),
        .col_pix  (blue_col),
        .quotient (blue_q)
    );

    gb5_lane u_lane_green (
        .clk      (clk),
        .shift    (s1_valid_reg),
        .col_pix  (green_col),
        .quotient (green_q)
    );

    gb5_lane u_lane_red (
        .clk      (clk),
        .shift    (s1_valid_reg),
        .col_pix  (red_col),
        .quotient (red_q)
    );

    // ------------------------------------------------------------------
    // Merge and result queue. A pixel request is taken only if its result,
    // together with every result still in the pipeline, fits in the queue.
    // ------------------------------------------------------------------
    gb5_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_push_reg),
        .red       (red_q),
        .green     (green_q),
        .blue      (blue_q),
        .row_end   (s4_tag_reg[1]),
        .frame_end (s4_tag_reg[0]),
        .count     (fifo_count),
        .res       (blurred)
    );

    assign pending = PEND_W'(s1_valid_reg && s1_flags_reg.produce) + PEND_W'(s2_push_reg)
                   + PEND_W'(s3_push_reg) + PEND_W'(s4_push_reg);

    assign credit_ok   = ({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(pending))
                         < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign video.ready = credit_ok;

`ifndef SYNTHESIS
    // The queue must never be asked to hold more than it has room for.
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(pending))
            <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wm1_reg)
        else $error("column counter beyond image width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= hm1_reg)
        else $error("row counter beyond image height");

    // The last pixel of a frame returns the raster position to the origin.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("frame did not wrap to origin");

    // A frame end flag is always also a row end flag.
    a_tag_order: assert property (@(posedge clk) disable iff (!rst_n)
        s4_push_reg && s4_tag_reg[0] |-> s4_tag_reg[1])
        else $error("frame end without row end");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the 5x5 binomial RGB blur: drives pixel and configuration
// requests, predicts every blurred pixel and compares it with the result channel.
// Depends on gb5_pkg, the channel interfaces in gb5_if and the block itself.

module tb_top;
    import gb5_pkg::*;

    // Register indexes past the two geometry registers. Writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Binomial taps per dimension; the 5x5 weights add up to 100.
    localparam int unsigned KERNEL [TAPS] = '{1, 2, 4, 2, 1};
    localparam int unsigned KERNEL_SUM = 100;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam int unsigned RESET_W = int'(RESET_WIDTH_M1) + 1;
    localparam int unsigned RESET_H = int'(RESET_HEIGHT_M1) + 1;

    // Cycles to let pixels that make no result leave the pipeline before a
    // register write, and the bound on waiting for outstanding results.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 1_000_000;

    logic clk = 1'b0;
    logic rst_n;

    gb5_pix_if video ();
    gb5_res_if blurred ();
    gb5_cfg_if cfg ();

    gaussian_blur_5x5_rgb_stream u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .video   (video),
        .blurred (blurred),
        .cfg     (cfg)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Blur predictor. It keeps its own copy of the geometry registers, the
    // four line stores, the five most recent vertical sums and the raster
    // position, and advances them for every accepted pixel request.
    // ------------------------------------------------------------------
    int unsigned img_width  = RESET_W;
    int unsigned img_height = RESET_H;
    bit [PIX_W-1:0]  line_mem [LINES][MAX_WIDTH];
    bit [VSUM_W-1:0] col_vsum [TAPS][3];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    // Blurred pixels that the block still owes, oldest at due_head.
    result_t     due_mem [int unsigned];
    int unsigned due_head = 0;
    int unsigned due_tail = 0;

    int fail_count = 0;

    // Idle rates in percent for the pixel sender and the result receiver, and
    // a countdown during which the receiver refuses every result.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned recv_hold_left = 0;

    function automatic int unsigned due_count();
        return due_tail - due_head;
    endfunction

    function automatic void due_add(input result_t item);
        due_mem[due_tail] = item;
        due_tail++;
    endfunction

    function automatic result_t due_take();
        result_t item;
        item = due_mem[due_head];
        due_mem.delete(due_head);
        due_head++;
        return item;
    endfunction

    function automatic void blur_step(input chan_t b, input chan_t g, input chan_t r);
        int unsigned w, h, c, hs;
        int i, k;
        bit [PIX_W-1:0] px;
        bit [PIX_W-1:0] column [TAPS];
        bit [VSUM_W-1:0] vs;
        chan_t ch [3];
        result_t res;
        bit last_col, last_row;

        // Out-of-range geometry saturates into the supported range.
        w = (img_width < MIN_SIZE) ? MIN_SIZE : (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
        h = (img_height < MIN_SIZE) ? MIN_SIZE :
            (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
        c = col_pos % MAX_WIDTH;
        px = {r, g, b};

        for (i = 0; i < LINES; i++)
            column[i] = line_mem[i][c];
        column[LINES] = px;

        // Vertical pass: slide the window one column and add the new column.
        for (i = 0; i < TAPS - 1; i++)
            for (k = 0; k < 3; k++)
                col_vsum[i][k] = col_vsum[i + 1][k];
        for (k = 0; k < 3; k++)
        begin
            vs = '0;
            for (i = 0; i < TAPS; i++)
                vs += VSUM_W'(KERNEL[i] * column[i][CHAN_W * k +: CHAN_W]);
            col_vsum[TAPS - 1][k] = vs;
        end

        // The column in the line stores moves up by one row.
        for (i = 0; i < LINES; i++)
            line_mem[i][c] = column[i + 1];

        last_col = (c + 1 >= w);
        last_row = (row_pos + 1 >= h);

        // Only a complete 5x5 window yields a pixel; border positions are silent.
        if (row_pos >= 4 && c >= 4)
        begin
            for (k = 0; k < 3; k++)
            begin
                hs = 0;
                for (i = 0; i < TAPS; i++)
                    hs += KERNEL[i] * col_vsum[i][k];
                ch[k] = chan_t'(hs / KERNEL_SUM);
            end
            res.blue      = ch[CH_BLUE];
            res.green     = ch[CH_GREEN];
            res.red       = ch[CH_RED];
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            due_add(res);
        end

        // Raster position wraps at the end of the row and of the frame.
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    // Every accepted pixel request goes through the predictor.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && video.valid === 1'b1 && video.ready === 1'b1)
            blur_step(video.blue_in, video.green_in, video.red_in);
    end

    // Register writes. Either geometry register restarts the frame; the spare
    // indexes leave the raster position alone. Width keeps only its low 11 bits.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && cfg.valid === 1'b1 && cfg.ready === 1'b1)
        begin
            if (cfg.index == CFG_IMAGE_WIDTH)
            begin
                img_width = cfg.data[IMG_W_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            else if (cfg.index == CFG_IMAGE_HEIGHT)
            begin
                img_height = cfg.data[IMG_H_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
        end
    end

    // Result checker: each accepted result is matched against the oldest
    // outstanding prediction, field by field.
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n === 1'b1 && blurred.valid === 1'b1 && blurred.ready === 1'b1)
        begin
            if (due_count() == 0)
            begin
                $error("blurred pixel arrived with none outstanding");
                fail_count++;
            end
            else
            begin
                want = due_take();
                if (blurred.blue_out !== want.blue)
                begin
                    $error("blue_out: expected %0d, got %0d", want.blue, blurred.blue_out);
                    fail_count++;
                end
                if (blurred.green_out !== want.green)
                begin
                    $error("green_out: expected %0d, got %0d", want.green, blurred.green_out);
                    fail_count++;
                end
                if (blurred.red_out !== want.red)
                begin
                    $error("red_out: expected %0d, got %0d", want.red, blurred.red_out);
                    fail_count++;
                end
                if (blurred.row_end !== want.row_end)
                begin
                    $error("row_end: expected %0d, got %0d", want.row_end, blurred.row_end);
                    fail_count++;
                end
                if (blurred.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d",
                           want.frame_end, blurred.frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Receiver side. A long hold is counted down here, one cycle per clock,
    // while the sender keeps offering pixels so the result queue fills up.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            blurred.ready <= 1'b0;
        end
        else if (recv_hold_left > 0)
        begin
            blurred.ready <= 1'b0;
            recv_hold_left--;
        end
        else
        begin
            blurred.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------

    // Channel value with the two extremes weighted up, so flat black and
    // flat white areas appear often enough to hit the top of the output range.
    function automatic chan_t pick_chan();
        int unsigned sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return chan_t'($urandom_range(255));
    endfunction

    // Offers one pixel request, idling first at the sender's rate, and returns
    // at the clock edge at which the block accepts it. Valid stays high so the
    // next request can follow without a gap.
    task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            video.valid <= 1'b0;
            @(posedge clk);
        end
        video.valid    <= 1'b1;
        video.blue_in  <= b;
        video.green_in <= g;
        video.red_in   <= r;
        do
            @(posedge clk);
        while (video.ready !== 1'b1);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            send_pixel(pick_chan(), pick_chan(), pick_chan());
    endtask

    // Stops offering pixels, waits for every outstanding result and then lets
    // pixels that produce nothing clear the pipeline, so the block is idle.
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        video.valid <= 1'b0;
        while (due_count() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (due_count() != 0)
        begin
            $error("%0d blurred pixels never arrived", due_count());
            fail_count++;
            due_mem.delete();
            due_head = due_tail;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write request. Valid is left high; the caller lowers it
    // once its last write has been taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
    endtask

    // Waits for the block to go idle, then writes both geometry registers in
    // a random order.
    task automatic write_geometry(input logic [CFG_DATA_W-1:0] w_data,
                                  input logic [CFG_DATA_W-1:0] h_data);
        drain_results();
        if ($urandom_range(1) == 0)
        begin
            write_reg(CFG_IMAGE_WIDTH, w_data);
            write_reg(CFG_IMAGE_HEIGHT, h_data);
        end
        else
        begin
            write_reg(CFG_IMAGE_HEIGHT, h_data);
            write_reg(CFG_IMAGE_WIDTH, w_data);
        end
        cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the geometry is 640 by 480. The start of the first row is
    // sent and must stay silent; the next register write cuts the frame short.
    task automatic test_reset_geometry();
        send_random_pixels(160);
    endtask

    // Smallest image: one result per frame, carrying both end flags. Blue is
    // flat white, green flat black and red a checkerboard of the extremes.
    task automatic test_min_frame();
        int unsigned row, col;
        write_geometry(CFG_DATA_W'(5), CFG_DATA_W'(5));
        for (row = 0; row < 5; row++)
            for (col = 0; col < 5; col++)
                send_pixel(8'hFF, 8'h00, ((row + col) % 2 == 1) ? 8'hFF : 8'h00);
    endtask

    // Three frames back to back with no register write between them, so the
    // raster position must wrap on its own at every frame end.
    task automatic test_frame_wraparound();
        write_geometry(CFG_DATA_W'(6), CFG_DATA_W'(5));
        send_random_pixels(3 * 6 * 5);
    endtask

    // Writes to the spare indexes in the middle of a frame change nothing:
    // the frame carries on where it stopped.
    task automatic test_spare_index();
        write_geometry(CFG_DATA_W'(7), CFG_DATA_W'(6));
        send_random_pixels(20);
        drain_results();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
        send_random_pixels(7 * 6 - 20 + 7 * 6);
    endtask

    // A write to either geometry register in the middle of a frame starts the
    // next pixel as the first of a new frame, even with an unchanged value.
    task automatic test_restart_mid_frame();
        write_geometry(CFG_DATA_W'(6), CFG_DATA_W'(6));
        send_random_pixels(23);
        drain_results();
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(6));
        cfg.valid <= 1'b0;
        send_random_pixels(6 * 6 + 17);
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(6));
        cfg.valid <= 1'b0;
        send_random_pixels(6 * 6);
    endtask

    // Width and height below five are raised to five.
    task automatic test_clamp_low();
        write_geometry(CFG_DATA_W'($urandom_range(4)), CFG_DATA_W'($urandom_range(4)));
        send_random_pixels(2 * 5 * 5);
    endtask

    // All thirteen data bits set on the width register: the upper two bits are
    // dropped and 2047 saturates to the line store width of 1024. Only the
    // start of the first row is sent before the next write restarts the frame.
    task automatic test_clamp_wide();
        write_geometry(13'h1FFF, CFG_DATA_W'(5));
        send_random_pixels(60);
    endtask

    // Height 8191 saturates to 4096 rows. Thirty rows of five are sent; each
    // interior row closes with a row end flag and none carries a frame end.
    // The width data carries stray upper bits that must be ignored.
    task automatic test_clamp_tall();
        write_geometry(13'h1805, 13'h1FFF);
        send_random_pixels(5 * 30);
    endtask

    // The receiver refuses results for a long stretch while pixel requests keep
    // coming, so the result queue fills and the pixel channel must stall.
    task automatic test_output_stall();
        write_geometry(CFG_DATA_W'(12), CFG_DATA_W'(10));
        recv_hold_left = 300;
        send_random_pixels(2 * 12 * 10);
    endtask

    // The sender stops in the middle of a frame until every result owed so far
    // has come out, then finishes the frame.
    task automatic test_sender_pause();
        write_geometry(CFG_DATA_W'(9), CFG_DATA_W'(8));
        send_random_pixels(50);
        video.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_count() != 0);
        send_random_pixels(9 * 8 - 50);
    endtask

    // Random geometry, mostly small, with whole frames of random content. Now
    // and then a frame is cut short by the next register write, and now and
    // then a spare index is written first.
    task automatic test_random_frames(input int unsigned pixel_budget);
        int unsigned sent, w, h, n;
        sent = 0;
        while (sent < pixel_budget)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
            h = $urandom_range(5, 9);
            drain_results();
            if ($urandom_range(7) == 0)
            begin
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          CFG_DATA_W'($urandom));
                cfg.valid <= 1'b0;
            end
            write_geometry({2'($urandom_range(3)), 11'(w)}, 13'(h));
            if ($urandom_range(5) == 0)
                n = $urandom_range(1, w * h - 1);
            else
                n = w * h * $urandom_range(1, 2);
            send_random_pixels(n);
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        video.valid    <= 1'b0;
        video.blue_in  <= '0;
        video.green_in <= '0;
        video.red_in   <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= CFG_IMAGE_WIDTH;
        cfg.data       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalling.
        send_idle_pct = 19;
        recv_idle_pct = 65;
        test_reset_geometry();
        test_min_frame();
        test_frame_wraparound();
        test_spare_index();
        test_restart_mid_frame();
        test_clamp_low();
        test_random_frames(150);

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 65;
        recv_idle_pct = 19;
        test_clamp_wide();
        test_random_frames(150);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_stall();
        test_sender_pause();
        test_clamp_tall();
        test_random_frames(100);

        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
